### hw/rtl/sha256_pkg.sv
// Package with the SHA-256 constants, round functions and sequencer state type.
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned NUM_ROUNDS  = 64;
    localparam int unsigned LEN_BITS    = 61;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam logic [5:0]  LEN_OFFSET  = 6'd56;

    localparam logic [31:0] K_TAB [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

### hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 hasher that takes one message byte per word and returns the digest as eight words.
// Input words are taken one per cycle while the sequencer is idle. The byte that fills a
// 64-byte block is taken, then 64 rounds run through the single round unit, and then the
// working variables are folded into the chain. At end of message the padding bytes are
// placed one per cycle (9 to 72 of them), with one or two more compressions, and then
// the eight digest words go out at one per cycle while not stalled. Input stall is high
// whenever the sequencer is not idle.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_last_word
);
    import sha256_pkg::*;

    t_state r_state, n_state;

    logic [31:0] r_chain [8];
    logic [31:0] n_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];

    logic [5:0]          r_fill, n_fill;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic [5:0]          r_round, n_round;
    logic [2:0]          r_idx, n_idx;
    logic                r_finish, n_finish;
    logic                r_mark, n_mark;
    logic                r_in_len, n_in_len;

    logic        in_acc;
    logic        out_acc;
    logic        place;
    logic        block_full;
    logic        pad_len_now;
    logic [63:0] len_bits;
    logic [63:0] len_shift;
    logic [7:0]  pad_byte;
    logic [7:0]  place_byte;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_EMIT);
    assign o_digest_word = r_chain[r_idx];
    assign o_last_word   = (r_idx == 3'd7);

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign len_bits    = {r_len, 3'b000};
    assign len_shift   = len_bits << {r_fill[2:0], 3'b000};
    assign pad_len_now = r_mark && (r_in_len || (r_fill == LEN_OFFSET));
    assign pad_byte    = !r_mark ? PAD_MARK : (pad_len_now ? len_shift[63:56] : 8'h00);

    assign place      = (in_acc && i_byte_present) || (r_state == ST_PAD);
    assign place_byte = (r_state == ST_PAD) ? pad_byte : i_data_byte;
    assign block_full = place && (r_fill == 6'(BLOCK_BYTES - 1));

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + K_TAB[r_round] + r_w[0];
    assign t2 = big_sigma0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_new = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (block_full) begin
                        n_state = ST_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_finish) begin
                    n_state = r_in_len ? ST_EMIT : ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (block_full) begin
                    n_state = ST_ROUND;
                end
            end
            ST_EMIT: begin
                if (out_acc && (r_idx == 3'd7)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_chain  = r_chain;
        n_v      = r_v;
        n_w      = r_w;
        n_fill   = r_fill;
        n_len    = r_len;
        n_round  = r_round;
        n_idx    = r_idx;
        n_finish = r_finish;
        n_mark   = r_mark;
        n_in_len = r_in_len;

        if (place) begin
            for (int j = 0; j < 15; j++) begin
                n_w[j] = {r_w[j][23:0], r_w[j+1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], place_byte};
            n_fill  = r_fill + 6'd1;
        end
        if (in_acc) begin
            n_finish = i_end_of_message;
            if (i_byte_present) begin
                n_len = r_len + LEN_BITS'(1);
            end
        end
        if (r_state == ST_PAD) begin
            if (!r_mark) begin
                n_mark = 1'b1;
            end else if (pad_len_now) begin
                n_in_len = 1'b1;
            end
        end
        if (block_full) begin
            n_v     = r_chain;
            n_round = 6'd0;
        end

        case (r_state)
            ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                for (int j = 0; j < 15; j++) begin
                    n_w[j] = r_w[j+1];
                end
                n_w[15] = w_new;
                n_round = r_round + 6'd1;
            end
            ST_FOLD: begin
                for (int j = 0; j < 8; j++) begin
                    n_chain[j] = r_chain[j] + r_v[j];
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_chain  = IV_TAB;
                        n_len    = '0;
                        n_fill   = '0;
                        n_finish = 1'b0;
                        n_mark   = 1'b0;
                        n_in_len = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= IV_TAB;
            r_fill   <= '0;
            r_len    <= '0;
            r_round  <= '0;
            r_idx    <= '0;
            r_finish <= 1'b0;
            r_mark   <= 1'b0;
            r_in_len <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_round  <= n_round;
            r_idx    <= n_idx;
            r_finish <= n_finish;
            r_mark   <= n_mark;
            r_in_len <= n_in_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_w <= n_w;
    end

endmodule
